### hdl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared constants, types and helpers for the TLV packet deframer.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam int HEADER_MAX = 10;
    localparam int HIDX_W     = $clog2(HEADER_MAX);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [31:0] MAX_SIZE_RESET = 32'd8800;

    localparam logic [7:0] TYPE_A = 8'h05;
    localparam logic [7:0] TYPE_B = 8'h06;
    localparam logic [7:0] LEN_16 = 8'hFD;
    localparam logic [7:0] LEN_32 = 8'hFE;
    localparam logic [7:0] LEN_64 = 8'hFF;

    // header sizes in bytes for each length form
    localparam logic [HIDX_W-1:0] NEED_SHORT = HIDX_W'(2);
    localparam logic [HIDX_W-1:0] NEED_16    = HIDX_W'(4);
    localparam logic [HIDX_W-1:0] NEED_32    = HIDX_W'(6);
    localparam logic [HIDX_W-1:0] NEED_64    = HIDX_W'(10);

    typedef enum logic {
        ST_SCAN,
        ST_EMIT
    } eng_state_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic        fin;
        logic [31:0] total;
    } result_t;

    typedef struct packed {
        logic res_valid;
        logic step_end;
    } eng_ctl_t;

    function automatic logic [HIDX_W-1:0] header_need(input logic [7:0] len_byte);
        logic [HIDX_W-1:0] n;
        unique case (len_byte)
            LEN_16:  n = NEED_16;
            LEN_32:  n = NEED_32;
            LEN_64:  n = NEED_64;
            default: n = NEED_SHORT;
        endcase
        return n;
    endfunction

    function automatic logic is_type(input logic [7:0] b);
        return (b == TYPE_A) || (b == TYPE_B);
    endfunction

endpackage

### hdl/tpd_in_queue.sv
// ----------------------------------------------------------------------------
// tpd_in_queue
// Short input queue that decouples the stream from the header engine.
// ----------------------------------------------------------------------------
module tpd_in_queue import tpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       q_valid,
    output logic [7:0] q_data,
    input  logic       q_pop
);

    logic [7:0]        mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              push;
    logic              pop;

    assign in_ready = (cnt_reg != (QPTR_W+1)'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= data_byte;
        end
    end

endmodule

### hdl/tpd_engine.sv
// ----------------------------------------------------------------------------
// tpd_engine
// Header hunting, size check, header replay and packet byte emission.
// ----------------------------------------------------------------------------
module tpd_engine import tpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] max_size,
    input  logic        q_valid,
    input  logic [7:0]  q_data,
    output logic        q_pop,
    input  logic        en,
    output eng_ctl_t    ctl,
    output result_t     res
);

    // buf_reg holds the open header in [0, hc) followed by plen bytes still
    // to be rescanned; both only ever shift down by one
    logic [7:0]        buf_reg [HEADER_MAX];
    logic [7:0]        buf_next [HEADER_MAX];
    logic [HIDX_W-1:0] hc_reg, hc_next;
    logic [HIDX_W-1:0] plen_reg, plen_next;
    logic              in_pkt_reg, in_pkt_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       tot_reg, tot_next;
    eng_state_t        state_reg, state_next;
    logic              first_reg, first_next;
    logic              empty_reg, empty_next;

    logic [7:0]        view [HEADER_MAX];
    logic [7:0]        shv [HEADER_MAX];
    logic [7:0]        shb [HEADER_MAX];
    logic              from_q;
    logic              have;
    logic [7:0]        cur;
    logic [HIDX_W-1:0] hcn;
    logic [HIDX_W-1:0] plen_after;
    logic [HIDX_W-1:0] need;
    logic [31:0]       lo32;
    logic              hi_nz;
    logic [32:0]       sum33;
    logic              oversize;

    always_comb
    begin
        from_q     = (plen_reg == '0);
        cur        = from_q ? q_data : buf_reg[hc_reg];
        have       = from_q ? q_valid : 1'b1;
        hcn        = hc_reg + 1'b1;
        plen_after = from_q ? '0 : plen_reg - 1'b1;

        for (int i = 0; i < HEADER_MAX; i++)
        begin
            view[i] = buf_reg[i];
        end
        view[hc_reg] = cur;

        for (int i = 0; i < HEADER_MAX - 1; i++)
        begin
            shv[i] = view[i + 1];
            shb[i] = buf_reg[i + 1];
        end
        shv[HEADER_MAX-1] = view[HEADER_MAX-1];
        shb[HEADER_MAX-1] = buf_reg[HEADER_MAX-1];

        // size check: value length is big-endian in view[2..need-1], or is view[1] itself for the short form
        need = header_need(view[1]);
        unique case (need)
            NEED_16: lo32 = {16'h0000, view[2], view[3]};
            NEED_32: lo32 = {view[2], view[3], view[4], view[5]};
            NEED_64: lo32 = {view[6], view[7], view[8], view[9]};
            default: lo32 = {24'h000000, view[1]};
        endcase
        hi_nz    = (need == NEED_64) && (|{view[2], view[3], view[4], view[5]});
        sum33    = {1'b0, lo32} + 33'(need);
        oversize = hi_nz || (sum33 > {1'b0, max_size});
    end

    always_comb
    begin
        buf_next    = buf_reg;
        hc_next     = hc_reg;
        plen_next   = plen_reg;
        in_pkt_next = in_pkt_reg;
        rem_next    = rem_reg;
        tot_next    = tot_reg;
        state_next  = state_reg;
        first_next  = first_reg;
        empty_next  = empty_reg;
        q_pop       = 1'b0;
        ctl         = '0;
        res.data    = cur;
        res.start   = 1'b0;
        res.fin     = 1'b0;
        res.total   = tot_reg;

        if (en)
        begin
            unique case (state_reg)
                ST_SCAN:
                begin
                    if (have)
                    begin
                        q_pop = from_q;
                        if ((hc_reg == '0) && (in_pkt_reg || !is_type(cur)))
                        begin
                            // packet body byte, or junk while hunting
                            buf_next      = shv;
                            plen_next     = plen_after;
                            ctl.step_end  = (plen_after == '0);
                            if (in_pkt_reg)
                            begin
                                rem_next      = rem_reg - 32'd1;
                                ctl.res_valid = 1'b1;
                                res.fin       = (rem_reg == 32'd1);
                                if (rem_reg == 32'd1)
                                begin
                                    in_pkt_next = 1'b0;
                                end
                            end
                        end
                        else if ((hcn >= NEED_SHORT) && (hcn == need))
                        begin
                            if (oversize)
                            begin
                                // drop type byte, rescan the rest of the header
                                buf_next     = shv;
                                hc_next      = '0;
                                plen_next    = hc_reg + plen_after;
                                ctl.step_end = ((hc_reg + plen_after) == '0);
                            end
                            else
                            begin
                                buf_next   = view;
                                hc_next    = hcn;
                                plen_next  = plen_after;
                                tot_next   = sum33[31:0];
                                rem_next   = sum33[31:0] - 32'(need);
                                empty_next = (sum33[31:0] == 32'(need));
                                first_next = 1'b1;
                                state_next = ST_EMIT;
                            end
                        end
                        else
                        begin
                            buf_next     = view;
                            hc_next      = hcn;
                            plen_next    = plen_after;
                            ctl.step_end = (plen_after == '0);
                        end
                    end
                end
                ST_EMIT:
                begin
                    ctl.res_valid = 1'b1;
                    res.data      = buf_reg[0];
                    res.start     = first_reg;
                    res.fin       = (hc_reg == HIDX_W'(1)) && empty_reg;
                    buf_next      = shb;
                    first_next    = 1'b0;
                    hc_next       = hc_reg - 1'b1;
                    if (hc_reg == HIDX_W'(1))
                    begin
                        state_next   = ST_SCAN;
                        in_pkt_next  = !empty_reg;
                        ctl.step_end = (plen_reg == '0);
                    end
                end
                default:
                begin
                    state_next = ST_SCAN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg     <= '0;
            plen_reg   <= '0;
            in_pkt_reg <= 1'b0;
            rem_reg    <= '0;
            tot_reg    <= '0;
            state_reg  <= ST_SCAN;
            first_reg  <= 1'b0;
            empty_reg  <= 1'b0;
        end
        else
        begin
            hc_reg     <= hc_next;
            plen_reg   <= plen_next;
            in_pkt_reg <= in_pkt_next;
            rem_reg    <= rem_next;
            tot_reg    <= tot_next;
            state_reg  <= state_next;
            first_reg  <= first_next;
            empty_reg  <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

### hdl/tpd_out_stage.sv
// ----------------------------------------------------------------------------
// tpd_out_stage
// Holds the latest word until its run is known to go on or end, then
// passes it to the output register with the run-last mark.
// ----------------------------------------------------------------------------
module tpd_out_stage import tpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  eng_ctl_t    ctl,
    input  result_t     res,
    output logic        en,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  packet_byte,
    output logic        packet_start,
    output logic        packet_end,
    output logic [31:0] packet_total,
    output logic        run_last
);

    result_t hold_reg, hold_next;
    logic    hold_valid_reg, hold_valid_next;
    logic    hold_final_reg, hold_final_next;
    result_t out_reg, out_next;
    logic    out_last_reg, out_last_next;
    logic    out_valid_reg, out_valid_next;
    logic    o_free;
    logic    move;

    assign o_free = !out_valid_reg || out_ready;
    assign en     = !hold_valid_reg || o_free;
    assign move   = hold_valid_reg && o_free && (hold_final_reg || ctl.res_valid);

    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        hold_final_next = hold_final_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg;

        if (move)
        begin
            out_next       = hold_reg;
            out_last_next  = hold_final_reg;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        priority if (ctl.res_valid)
        begin
            hold_next       = res;
            hold_valid_next = 1'b1;
            hold_final_next = ctl.step_end;
        end
        else if (move)
        begin
            hold_valid_next = 1'b0;
        end
        else if (ctl.step_end && hold_valid_reg)
        begin
            hold_final_next = 1'b1;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            hold_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            hold_final_reg <= hold_final_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign packet_byte  = out_reg.data;
    assign packet_start = out_reg.start;
    assign packet_end   = out_reg.fin;
    assign packet_total = out_reg.total;
    assign run_last     = out_last_reg;

endmodule

### hdl/tlv_packet_deframer.sv
// ----------------------------------------------------------------------------
// tlv_packet_deframer: cuts type 0x05/0x06 TLV packets out of a byte stream.
// A body byte passes the input queue, the hold and the output registers.
// Throughput: 1 byte/cycle while out_ready stays high; the engine takes no
// input while it replays a header (2..10 bytes) or a dropped one (<= 9).
// Reset: hunting for a type byte, input queue empty, max_packet_size = 8800.
// ----------------------------------------------------------------------------
module tlv_packet_deframer import tpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  packet_byte,
    output logic        packet_start,
    output logic        packet_end,
    output logic [31:0] packet_total,
    output logic        run_last
);

    logic [31:0] max_size_reg, max_size_next;
    logic        q_valid;
    logic [7:0]  q_data;
    logic        q_pop;
    logic        en;
    eng_ctl_t    ctl;
    result_t     res;

    assign cfg_ready     = 1'b1;
    assign max_size_next = (cfg_valid && cfg_ready) ? cfg_data : max_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg <= MAX_SIZE_RESET;
        end
        else
        begin
            max_size_reg <= max_size_next;
        end
    end

    tpd_in_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop)
    );

    tpd_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .max_size (max_size_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .en       (en),
        .ctl      (ctl),
        .res      (res)
    );

    tpd_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .res          (res),
        .en           (en),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packet_byte  (packet_byte),
        .packet_start (packet_start),
        .packet_end   (packet_end),
        .packet_total (packet_total),
        .run_last     (run_last)
    );

endmodule

### hdl/tpd_checker.sv
// ----------------------------------------------------------------------------
// tpd_checker
// Port-level checks on the deframer output, bound to the top level.
// ----------------------------------------------------------------------------
module tpd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  packet_byte,
    input logic        packet_start,
    input logic        packet_end,
    input logic [31:0] packet_total,
    input logic        run_last
);

    // output register is cleared while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output word valid during reset");

    // a header is at least two bytes, so start and end never share a word
    a_start_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(packet_start && packet_end))
        else $error("start and end on the same word");

    a_total_min: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && packet_start) |-> (packet_total >= 32'd2))
        else $error("packet total below header size");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(packet_byte)
            && $stable(packet_start) && $stable(packet_end)
            && $stable(packet_total) && $stable(run_last)))
        else $error("output word changed while stalled");

endmodule

bind tlv_packet_deframer tpd_checker u_tpd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .packet_byte  (packet_byte),
    .packet_start (packet_start),
    .packet_end   (packet_end),
    .packet_total (packet_total),
    .run_last     (run_last)
);
